[hdl/bgho_pkg.sv]
`timescale 1ns / 1ps
// bgho_pkg: field widths, register codes, reset values and pipeline structs
// for the bilinear height grid. No dependencies.
package bgho_pkg;

   // port field widths
   localparam int HEIGHT_W   = 18;
   localparam int POS_W      = 21;
   localparam int RECIP_W    = 24;
   localparam int Z_W        = 19;
   localparam int ENTRY_W    = 6;
   localparam int CNT_REG_W  = 4;
   localparam int CSR_IDX_W  = 4;
   localparam int CSR_DATA_W = 24;

   // cell locate: |pos| * recip, integer part from bit 34, 16 bit fraction below
   localparam int MAG_W    = POS_W;
   localparam int PROD_W   = MAG_W + RECIP_W;
   localparam int INT_LSB  = 34;
   localparam int FRAC_LSB = 18;
   localparam int IP_W     = PROD_W - INT_LSB;
   localparam int FM_W     = INT_LSB - FRAC_LSB;
   localparam int FRAC_W   = FM_W + 1;

   // blend datapath
   localparam int PX_W      = FRAC_W + HEIGHT_W + 1;
   localparam int A_W       = HEIGHT_W + FRAC_W + 2;
   localparam int D_W       = A_W + 1;
   localparam int PY_W      = FRAC_W + D_W;
   localparam int V_W       = PY_W + 1;
   localparam int SHIFT_OUT = 32;
   localparam int R_W       = V_W - SHIFT_OUT;
   localparam int Z_MAX     = 262143;
   localparam int Z_MIN     = -262144;

   // request function codes
   localparam logic FUNC_WRITE = 1'b0;
   localparam logic FUNC_QUERY = 1'b1;

   // register reset values
   localparam logic [CNT_REG_W-1:0] ROWS_RESET  = CNT_REG_W'(5);
   localparam logic [CNT_REG_W-1:0] COLS_RESET  = CNT_REG_W'(5);
   localparam logic [RECIP_W-1:0]   RECIP_RESET = RECIP_W'(335544);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_GRID_ROWS   = 4'd0,
      CSR_GRID_COLS   = 4'd1,
      CSR_X_RECIP     = 4'd2,
      CSR_Y_RECIP     = 4'd3
   } csr_index_type;

   typedef struct packed {
      logic                     in_range;
      logic [IP_W-1:0]          ip;
      logic signed [FRAC_W-1:0] frac;
   } loc_type;

   typedef struct packed {
      logic valid;
      logic query;
      logic oog;
   } ctl_type;

endpackage

[hdl/bilinear_grid_height_offset.sv]
`timescale 1ns / 1ps
// bilinear_grid_height_offset: bed height grid with bilinear offset lookup.
// Depends on bgho_pkg, bgho_locate, bgho_grid_bank, bgho_blend.
//
//  channel   direction  handshake                 payload
//  ---------------------------------------------------------------------------
//  req_      in         start & !busy             func, entry_index, height,
//                                                 x_pos, y_pos
//  rsp_      out        rsp_valid, one cycle      z_offset, out_of_grid
//  csr_      in         csr_valid & csr_ready     csr_index, csr_wdata
//
// One transaction per clock: busy never rises and csr_ready is always high.
// A query's result is strobed on rsp_valid after stages a..h, in order:
// locate magnitude, locate multiply, cell split, store read, two blend
// multiplies with their adds, round/saturate.
// Height writes give no result; they land in the store at stage c, the
// same stage where queries read, so order is kept.
// Reset is synchronous; it clears the pipeline valids, the store's valid
// bits (unwritten entries read as zero) and the registers. No clearing pass.
// The receiver cannot stall, so the pipeline never holds.
module bilinear_grid_height_offset import bgho_pkg::*; #(
   parameter int MAX_ROWS = 8,
   parameter int MAX_COLS = 8
) (
   input  logic                        clock,
   input  logic                        reset,
   // request
   input  logic                        start,
   output logic                        busy,
   input  logic                        req_func,
   input  logic [ENTRY_W-1:0]          req_entry_index,
   input  logic signed [HEIGHT_W-1:0]  req_height,
   input  logic signed [POS_W-1:0]     req_x_pos,
   input  logic signed [POS_W-1:0]     req_y_pos,
   // result
   output logic                        rsp_valid,
   output logic signed [Z_W-1:0]       rsp_z_offset,
   output logic                        rsp_out_of_grid,
   // configuration
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [CSR_IDX_W-1:0]        csr_index,
   input  logic [CSR_DATA_W-1:0]       csr_wdata
);

   localparam int DEPTH  = MAX_ROWS * MAX_COLS;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int ROW_W  = $clog2(MAX_ROWS);
   localparam int COL_W  = $clog2(MAX_COLS);
   localparam int RCNT_W = $clog2(MAX_ROWS + 1);
   localparam int CCNT_W = $clog2(MAX_COLS + 1);
   localparam int MUL_W  = ROW_W + CCNT_W;

   // configuration registers
   logic [CNT_REG_W-1:0] rows_ff, cols_ff;
   logic [RECIP_W-1:0]   x_recip_ff, y_recip_ff;

   // request pipeline, stages a..d
   logic                       accept;
   ctl_type                    ctl_a_ff, ctl_b_ff, ctl_c_ff, ctl_d_ff;
   logic [ENTRY_W-1:0]         entry_a_ff, entry_b_ff, entry_c_ff;
   logic signed [HEIGHT_W-1:0] height_a_ff, height_b_ff, height_c_ff;
   logic signed [FRAC_W-1:0]   fx_d_ff, fy_d_ff;

   // cell locate results, aligned with stage c
   loc_type loc_x, loc_y;

   // stage c address generation
   logic [RCNT_W-1:0]          rows_eff;
   logic [CCNT_W-1:0]          cols_eff;
   logic [ROW_W-1:0]           xi, xi2;
   logic [COL_W-1:0]           yi, yi2;
   logic [RCNT_W:0]            xi_next;
   logic [CCNT_W:0]            yi_next;
   logic [MUL_W-1:0]           row_base, row_base2;
   logic [ADDR_W-1:0]          addr00, addr10, addr01, addr11;
   logic                       wr_en;
   logic [ADDR_W-1:0]          wr_addr;
   logic signed [HEIGHT_W-1:0] h00, h10, h01, h11;

   assign accept    = start && !busy;
   assign busy      = 1'b0;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_ff    <= ROWS_RESET;
         cols_ff    <= COLS_RESET;
         x_recip_ff <= RECIP_RESET;
         y_recip_ff <= RECIP_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_GRID_ROWS: rows_ff    <= csr_wdata[CNT_REG_W-1:0];
            CSR_GRID_COLS: cols_ff    <= csr_wdata[CNT_REG_W-1:0];
            CSR_X_RECIP:   x_recip_ff <= csr_wdata[RECIP_W-1:0];
            CSR_Y_RECIP:   y_recip_ff <= csr_wdata[RECIP_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // grid size in use, clamped to the store
   always_comb begin
      rows_eff = (32'(rows_ff) > MAX_ROWS) ? RCNT_W'(MAX_ROWS) : RCNT_W'(rows_ff);
      cols_eff = (32'(cols_ff) > MAX_COLS) ? CCNT_W'(MAX_COLS) : CCNT_W'(cols_ff);
   end

   bgho_locate u_locate_x (
      .clock (clock),
      .pos   (req_x_pos),
      .recip (x_recip_ff),
      .limit (IP_W'(rows_eff)),
      .loc   (loc_x)
   );

   bgho_locate u_locate_y (
      .clock (clock),
      .pos   (req_y_pos),
      .recip (y_recip_ff),
      .limit (IP_W'(cols_eff)),
      .loc   (loc_y)
   );

   // control travels alongside the locate stages
   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_a_ff <= '0;
         ctl_b_ff <= '0;
         ctl_c_ff <= '0;
         ctl_d_ff <= '0;
      end else begin
         ctl_a_ff.valid <= accept;
         ctl_a_ff.query <= (req_func == FUNC_QUERY);
         ctl_a_ff.oog   <= 1'b0;
         ctl_b_ff       <= ctl_a_ff;
         ctl_c_ff       <= ctl_b_ff;
         ctl_d_ff.valid <= ctl_c_ff.valid;
         ctl_d_ff.query <= ctl_c_ff.query;
         ctl_d_ff.oog   <= !(loc_x.in_range && loc_y.in_range);
      end
   end

   always_ff @(posedge clock) begin
      entry_a_ff  <= req_entry_index;
      height_a_ff <= req_height;
      entry_b_ff  <= entry_a_ff;
      height_b_ff <= height_a_ff;
      entry_c_ff  <= entry_b_ff;
      height_c_ff <= height_b_ff;
      fx_d_ff     <= loc_x.frac;
      fy_d_ff     <= loc_y.frac;
   end

   // stage c: neighbour indices (upper one clamped at the last row/column)
   // and row-major addresses. Out-of-grid indices give junk addresses whose
   // reads are discarded downstream.
   always_comb begin
      xi      = loc_x.ip[ROW_W-1:0];
      yi      = loc_y.ip[COL_W-1:0];
      xi_next = (RCNT_W + 1)'(xi) + 1'b1;
      yi_next = (CCNT_W + 1)'(yi) + 1'b1;
      xi2     = (xi_next < (RCNT_W + 1)'(rows_eff)) ? xi_next[ROW_W-1:0] : xi;
      yi2     = (yi_next < (CCNT_W + 1)'(cols_eff)) ? yi_next[COL_W-1:0] : yi;

      row_base  = MUL_W'(xi)  * MUL_W'(cols_eff);
      row_base2 = MUL_W'(xi2) * MUL_W'(cols_eff);
      addr00    = ADDR_W'(row_base)  + ADDR_W'(yi);
      addr10    = ADDR_W'(row_base2) + ADDR_W'(yi);
      addr01    = ADDR_W'(row_base)  + ADDR_W'(yi2);
      addr11    = ADDR_W'(row_base2) + ADDR_W'(yi2);

      // writes beyond the store are dropped
      wr_en   = ctl_c_ff.valid && !ctl_c_ff.query && (32'(entry_c_ff) < DEPTH);
      wr_addr = ADDR_W'(entry_c_ff);
   end

   // four copies of the store, one per corner, all written together
   bgho_grid_bank #(.DEPTH(DEPTH)) u_bank_00 (
      .clock     (clock),
      .reset     (reset),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_height (height_c_ff),
      .rd_addr   (addr00),
      .rd_height (h00)
   );

   bgho_grid_bank #(.DEPTH(DEPTH)) u_bank_10 (
      .clock     (clock),
      .reset     (reset),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_height (height_c_ff),
      .rd_addr   (addr10),
      .rd_height (h10)
   );

   bgho_grid_bank #(.DEPTH(DEPTH)) u_bank_01 (
      .clock     (clock),
      .reset     (reset),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_height (height_c_ff),
      .rd_addr   (addr01),
      .rd_height (h01)
   );

   bgho_grid_bank #(.DEPTH(DEPTH)) u_bank_11 (
      .clock     (clock),
      .reset     (reset),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_height (height_c_ff),
      .rd_addr   (addr11),
      .rd_height (h11)
   );

   // stages e..h: blend, round, saturate, result register
   bgho_blend u_blend (
      .clock       (clock),
      .reset       (reset),
      .ctl         (ctl_d_ff),
      .h00         (h00),
      .h10         (h10),
      .h01         (h01),
      .h11         (h11),
      .fx          (fx_d_ff),
      .fy          (fy_d_ff),
      .rsp_valid   (rsp_valid),
      .z_offset    (rsp_z_offset),
      .out_of_grid (rsp_out_of_grid)
   );

endmodule

[hdl/bgho_locate.sv]
`timescale 1ns / 1ps
// bgho_locate: three stage cell locate for one axis (magnitude, product, split).
// Depends on bgho_pkg.
module bgho_locate import bgho_pkg::*; (
   input  logic                     clock,
   input  logic signed [POS_W-1:0]  pos,
   input  logic [RECIP_W-1:0]       recip,
   input  logic [IP_W-1:0]          limit,
   output loc_type                  loc
);

   logic               neg_a_ff;
   logic [MAG_W-1:0]   mag_a_ff, mag_a_in;
   logic               neg_b_ff;
   logic [PROD_W-1:0]  prod_b_ff, prod_b_in;
   loc_type            loc_ff, loc_in;
   logic [IP_W-1:0]    ip;
   logic [FM_W-1:0]    fm;

   always_comb begin
      mag_a_in  = pos[POS_W-1] ? MAG_W'(-pos) : MAG_W'(pos);
      prod_b_in = PROD_W'(mag_a_ff) * PROD_W'(recip);
      ip        = prod_b_ff[PROD_W-1:INT_LSB];
      fm        = prod_b_ff[INT_LSB-1:FRAC_LSB];
      // negative side is only usable inside the first cell
      loc_in.in_range = !(neg_b_ff && (ip != '0)) && (ip < limit);
      loc_in.ip       = ip;
      loc_in.frac     = neg_b_ff ? -$signed({1'b0, fm}) : $signed({1'b0, fm});
   end

   always_ff @(posedge clock) begin
      neg_a_ff  <= pos[POS_W-1];
      mag_a_ff  <= mag_a_in;
      neg_b_ff  <= neg_a_ff;
      prod_b_ff <= prod_b_in;
      loc_ff    <= loc_in;
   end

   assign loc = loc_ff;

endmodule

[hdl/bgho_grid_bank.sv]
`timescale 1ns / 1ps
// bgho_grid_bank: one copy of the height store, one write and one registered
// read port; entries never written read as zero. Depends on bgho_pkg.
module bgho_grid_bank import bgho_pkg::*; #(
   parameter int DEPTH = 64
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         wr_en,
   input  logic [$clog2(DEPTH)-1:0]     wr_addr,
   input  logic signed [HEIGHT_W-1:0]   wr_height,
   input  logic [$clog2(DEPTH)-1:0]     rd_addr,
   output logic signed [HEIGHT_W-1:0]   rd_height
);

   logic signed [HEIGHT_W-1:0] mem [DEPTH];
   logic [DEPTH-1:0]           vld_ff;
   logic signed [HEIGHT_W-1:0] rd_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (wr_en) begin
         vld_ff[wr_addr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_height;
      end
      rd_ff <= vld_ff[rd_addr] ? mem[rd_addr] : '0;
   end

   assign rd_height = rd_ff;

endmodule

[hdl/bgho_blend.sv]
`timescale 1ns / 1ps
// bgho_blend: four stage bilinear blend, round and saturate, result register.
// Depends on bgho_pkg.
module bgho_blend import bgho_pkg::*; (
   input  logic                        clock,
   input  logic                        reset,
   input  ctl_type                     ctl,
   input  logic signed [HEIGHT_W-1:0]  h00,
   input  logic signed [HEIGHT_W-1:0]  h10,
   input  logic signed [HEIGHT_W-1:0]  h01,
   input  logic signed [HEIGHT_W-1:0]  h11,
   input  logic signed [FRAC_W-1:0]    fx,
   input  logic signed [FRAC_W-1:0]    fy,
   output logic                        rsp_valid,
   output logic signed [Z_W-1:0]       z_offset,
   output logic                        out_of_grid
);

   localparam logic signed [V_W-1:0] ROUND = V_W'(1) <<< (SHIFT_OUT - 1);

   ctl_type ctl_e_ff, ctl_f_ff, ctl_g_ff;

   logic signed [HEIGHT_W:0]   diff0, diff1;
   logic signed [PX_W-1:0]     px0_e_ff, px0_e_in, px1_e_ff, px1_e_in;
   logic signed [HEIGHT_W-1:0] h00_e_ff, h01_e_ff;
   logic signed [FRAC_W-1:0]   fy_e_ff, fy_f_ff;

   logic signed [A_W-1:0]      a_f_in, b_f_in, a_f_ff, a_g_ff;
   logic signed [D_W-1:0]      d_f_ff, d_f_in;
   logic signed [PY_W-1:0]     py_g_ff, py_g_in;

   logic signed [V_W-1:0]      v;
   logic signed [R_W-1:0]      r;
   logic signed [Z_W-1:0]      z_in, z_ff;
   logic                       valid_ff, oog_ff;

   always_comb begin
      // x blend written as h_lo*2^16 + fx*(h_hi - h_lo)
      diff0    = (HEIGHT_W + 1)'(h10) - (HEIGHT_W + 1)'(h00);
      diff1    = (HEIGHT_W + 1)'(h11) - (HEIGHT_W + 1)'(h01);
      px0_e_in = PX_W'(fx) * PX_W'(diff0);
      px1_e_in = PX_W'(fx) * PX_W'(diff1);

      a_f_in = (A_W'(h00_e_ff) <<< FM_W) + A_W'(px0_e_ff);
      b_f_in = (A_W'(h01_e_ff) <<< FM_W) + A_W'(px1_e_ff);
      d_f_in = D_W'(b_f_in) - D_W'(a_f_in);

      py_g_in = PY_W'(fy_f_ff) * PY_W'(d_f_ff);

      // round half up, floor shift
      v = (V_W'(a_g_ff) <<< FM_W) + V_W'(py_g_ff) + ROUND;
      r = v[V_W-1:SHIFT_OUT];
      if (r > R_W'(Z_MAX)) begin
         z_in = Z_W'(Z_MAX);
      end else if (r < R_W'(Z_MIN)) begin
         z_in = Z_W'(Z_MIN);
      end else begin
         z_in = Z_W'(r);
      end
      if (ctl_g_ff.oog) begin
         z_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_e_ff <= '0;
         ctl_f_ff <= '0;
         ctl_g_ff <= '0;
         valid_ff <= 1'b0;
      end else begin
         ctl_e_ff <= ctl;
         ctl_f_ff <= ctl_e_ff;
         ctl_g_ff <= ctl_f_ff;
         valid_ff <= ctl_g_ff.valid && ctl_g_ff.query;
      end
   end

   always_ff @(posedge clock) begin
      px0_e_ff <= px0_e_in;
      px1_e_ff <= px1_e_in;
      h00_e_ff <= h00;
      h01_e_ff <= h01;
      fy_e_ff  <= fy;
      a_f_ff   <= a_f_in;
      d_f_ff   <= d_f_in;
      fy_f_ff  <= fy_e_ff;
      a_g_ff   <= a_f_ff;
      py_g_ff  <= py_g_in;
      z_ff     <= z_in;
      oog_ff   <= ctl_g_ff.oog;
   end

   assign rsp_valid   = valid_ff;
   assign z_offset    = z_ff;
   assign out_of_grid = oog_ff;

endmodule

[verif/tb_top.sv]
`timescale 1ns / 1ps
// tb_top: self-checking bench for bilinear_grid_height_offset, with a directed
// table then randomised phases. Depends on bgho_pkg and the block under test.
module tb_top;
   import bgho_pkg::*;

   localparam int          GRID_ROWS_MAX  = 8;
   localparam int          GRID_COLS_MAX  = 8;
   localparam int          STORE_DEPTH    = GRID_ROWS_MAX * GRID_COLS_MAX;
   localparam int          NUM_DIRECTED   = 23;
   localparam int          NUM_PHASES     = 8;
   localparam int          PHASE_ITEMS    = 235;
   localparam int          SETTLE_CYCLES  = 12;      // pipeline is 8 deep, plus margin
   localparam int          CYCLE_LIMIT    = 300000;
   localparam logic [CSR_IDX_W-1:0] CSR_UNMAPPED = 4'hF;  // no register behind it

   typedef struct {
      logic                       func;
      logic [ENTRY_W-1:0]         entry;
      logic signed [HEIGHT_W-1:0] height;
      logic signed [POS_W-1:0]    x;
      logic signed [POS_W-1:0]    y;
   } grid_req_type;

   // directed row: request plus a hand-written result where one is obvious
   typedef struct {
      logic                       func;
      logic [ENTRY_W-1:0]         entry;
      logic signed [HEIGHT_W-1:0] height;
      logic signed [POS_W-1:0]    x;
      logic signed [POS_W-1:0]    y;
      logic                       typed;
      logic signed [Z_W-1:0]      z;
      logic                       oog;
   } stim_row_type;

   typedef struct {
      logic signed [Z_W-1:0] z;
      logic                  oog;
   } offset_type;

   // DUT connections, inputs all known from time zero
   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       start = 1'b0;
   logic                       busy;
   logic                       req_func = FUNC_WRITE;
   logic [ENTRY_W-1:0]         req_entry_index = '0;
   logic signed [HEIGHT_W-1:0] req_height = '0;
   logic signed [POS_W-1:0]    req_x_pos = '0;
   logic signed [POS_W-1:0]    req_y_pos = '0;
   logic                       rsp_valid;
   logic signed [Z_W-1:0]      rsp_z_offset;
   logic                       rsp_out_of_grid;
   logic                       csr_valid = 1'b0;
   logic                       csr_ready;
   logic [CSR_IDX_W-1:0]       csr_index = '0;
   logic [CSR_DATA_W-1:0]      csr_wdata = '0;

   // shadow of the block: height store and registers
   logic signed [HEIGHT_W-1:0] height_store [STORE_DEPTH];
   logic [CNT_REG_W-1:0]       rows_cfg;
   logic [CNT_REG_W-1:0]       cols_cfg;
   logic [RECIP_W-1:0]         x_recip_cfg;
   logic [RECIP_W-1:0]         y_recip_cfg;

   offset_type    pending_offsets [$];
   int            fail_count  = 0;
   int            cycle_count = 0;
   stim_row_type  directed_rows [NUM_DIRECTED];

   bilinear_grid_height_offset uut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_func        (req_func),
      .req_entry_index (req_entry_index),
      .req_height      (req_height),
      .req_x_pos       (req_x_pos),
      .req_y_pos       (req_y_pos),
      .rsp_valid       (rsp_valid),
      .rsp_z_offset    (rsp_z_offset),
      .rsp_out_of_grid (rsp_out_of_grid),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Run guard. Counts every edge, reset included.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("[bilinear_grid_height_offset] ERROR");
         $finish;
      end
   end

   function automatic void note_failure(input string what);
      fail_count++;
      if (fail_count <= 10)
         $display("mismatch @%0t: %s", $realtime, what);
   endfunction

   // Cell locate: |pos|*recip in Q.34, index from bit 34, 16 bit fraction
   // from bits 18..33, sign put back on the fraction so truncation is toward zero.
   // False when the index falls off the grid (negative, or >= lim).
   function automatic logic find_cell(input logic signed [POS_W-1:0] pos,
                                      input logic [RECIP_W-1:0] recip,
                                      input longint unsigned lim,
                                      output longint unsigned idx,
                                      output longint frac);
      longint          p;
      longint unsigned mag;
      longint unsigned ip;
      longint unsigned fm;
      logic            neg;
      p    = pos;
      neg  = (p < 0);
      mag  = neg ? -p : p;
      mag  = mag * recip;
      ip   = mag >> 34;
      fm   = (mag >> 18) & 64'hFFFF;
      idx  = ip;
      frac = neg ? -longint'(fm) : longint'(fm);
      return !(neg && ip != 0) && (ip < lim);
   endfunction

   // Bilinear blend of the four neighbours, upper neighbour clamped at the
   // last row/column, rounded half up and saturated to the output width.
   function automatic void predict_offset(input logic signed [POS_W-1:0] x,
                                          input logic signed [POS_W-1:0] y,
                                          output offset_type res);
      longint unsigned rows, cols, xi, yi, xi2, yi2;
      longint          fx, fy, h00, h10, h01, h11, a, b, v;
      rows = (rows_cfg > GRID_ROWS_MAX) ? GRID_ROWS_MAX : rows_cfg;
      cols = (cols_cfg > GRID_COLS_MAX) ? GRID_COLS_MAX : cols_cfg;
      if (!find_cell(x, x_recip_cfg, rows, xi, fx) ||
          !find_cell(y, y_recip_cfg, cols, yi, fy)) begin
         res.z   = '0;
         res.oog = 1'b1;
         return;
      end
      xi2 = (xi + 1 < rows) ? xi + 1 : xi;
      yi2 = (yi + 1 < cols) ? yi + 1 : yi;
      h00 = height_store[xi  * cols + yi];
      h10 = height_store[xi2 * cols + yi];
      h01 = height_store[xi  * cols + yi2];
      h11 = height_store[xi2 * cols + yi2];
      a = (65536 - fx) * h00 + fx * h10;
      b = (65536 - fx) * h01 + fx * h11;
      v = fy * b + (65536 - fy) * a;
      v = (v + (64'sd1 <<< 31)) >>> 32;
      if (v > Z_MAX) v = Z_MAX;
      if (v < Z_MIN) v = Z_MIN;
      res.z   = v[Z_W-1:0];
      res.oog = 1'b0;
   endfunction

   // Position along one axis, mostly aimed at the grid in use.
   function automatic logic signed [POS_W-1:0] pick_pos(input logic [RECIP_W-1:0] recip,
                                                        input logic [CNT_REG_W-1:0] lim);
      longint span;
      longint hi;
      longint p;
      int     r;
      span = (64'sd1 << 34) / recip;
      if (span > 2097152) span = 2097152;
      hi = span * ((lim == 0) ? 1 : ((lim > GRID_ROWS_MAX) ? GRID_ROWS_MAX : lim)) + span / 2;
      if (hi > 1048575) hi = 1048575;
      r = $urandom_range(0, 99);
      if (r < 8)
         p = longint'(signed'(POS_W'($urandom)));
      else if (r < 16)
         case ($urandom_range(0, 3))
            0:       p = -1048576;
            1:       p = 1048575;
            2:       p = 0;
            default: p = -1;
         endcase
      else if (r < 28)            // just below zero: extrapolation
         p = -longint'($urandom_range(1, int'((span > 1048576) ? 1048576 : span)));
      else
         p = longint'($urandom_range(0, int'(hi)));
      return p[POS_W-1:0];
   endfunction

   function automatic logic signed [HEIGHT_W-1:0] pick_height();
      if ($urandom_range(0, 99) < 15)
         case ($urandom_range(0, 4))
            0:       return 18'sd131071;
            1:       return -18'sd131072;
            2:       return 18'sd0;
            3:       return -18'sd1;
            default: return 18'sd1;
         endcase
      return HEIGHT_W'($urandom);
   endfunction

   // Presents one request and holds it until the block takes it. The shadow
   // is updated just before the accepting edge, so order matches the block.
   // start is left high; the caller lowers it only when it wants a gap.
   task automatic send_request(input grid_req_type rq, input logic typed,
                               input logic signed [Z_W-1:0] tz, input logic toog);
      offset_type res;
      req_func        <= rq.func;
      req_entry_index <= rq.entry;
      req_height      <= rq.height;
      req_x_pos       <= rq.x;
      req_y_pos       <= rq.y;
      start           <= 1'b1;
      @(negedge clock);
      while (busy) begin
         @(posedge clock);
         @(negedge clock);
      end
      if (rq.func == FUNC_WRITE) begin
         height_store[rq.entry] = rq.height;
      end else begin
         if (typed) begin
            res.z   = tz;
            res.oog = toog;
         end else begin
            predict_offset(rq.x, rq.y, res);
         end
         pending_offsets.push_back(res);
      end
      @(posedge clock);
   endtask

   // Idle cycles after a transaction; each cycle idles with the given odds
   // in a hundred.
   task automatic maybe_idle(input int idle_pct);
      if ($urandom_range(0, 99) < idle_pct) begin
         start <= 1'b0;
         do
            @(posedge clock);
         while ($urandom_range(0, 99) < idle_pct);
      end
   endtask

   // valid is left high so back-to-back writes never toggle it in one step
   task automatic csr_write(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(negedge clock);
      while (!csr_ready) begin
         @(posedge clock);
         @(negedge clock);
      end
      case (idx)
         CSR_GRID_ROWS: rows_cfg    = data[CNT_REG_W-1:0];
         CSR_GRID_COLS: cols_cfg    = data[CNT_REG_W-1:0];
         CSR_X_RECIP:   x_recip_cfg = data[RECIP_W-1:0];
         CSR_Y_RECIP:   y_recip_cfg = data[RECIP_W-1:0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   // Stop issuing, let every outstanding result come back, then let trailing
   // height writes (no result) clear the pipe.
   task automatic drain_pipeline();
      start <= 1'b0;
      while (pending_offsets.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Result checker. Sampled mid-cycle, well clear of the driving edge.
   always @(negedge clock) begin : offset_check
      offset_type want;
      if (!reset && rsp_valid) begin
         if (pending_offsets.size() == 0) begin
            note_failure($sformatf("unexpected result z=%0d oog=%0b",
                                   rsp_z_offset, rsp_out_of_grid));
         end else begin
            want = pending_offsets.pop_front();
            if (rsp_z_offset !== want.z || rsp_out_of_grid !== want.oog)
               note_failure($sformatf("z_offset exp %0d got %0d, out_of_grid exp %0b got %0b",
                                      want.z, rsp_z_offset, want.oog, rsp_out_of_grid));
         end
      end
   end

   initial begin : main
      grid_req_type               rq;
      int                         idle_pct;
      logic [CNT_REG_W-1:0]       ph_rows, ph_cols;
      logic [RECIP_W-1:0]         ph_xr, ph_yr;

      // shadow matches reset values
      for (int i = 0; i < STORE_DEPTH; i++) height_store[i] = '0;
      rows_cfg    = ROWS_RESET;
      cols_cfg    = COLS_RESET;
      x_recip_cfg = RECIP_RESET;
      y_recip_cfg = RECIP_RESET;

      // Directed table, reset config: 5x5 grid, 50 mm cells (51200 counts).
      // Heights live at row*5+col.
      //                func        ent  height        x             y        typed z            oog
      directed_rows = '{
         '{FUNC_QUERY, 6'd0,  18'sd0,       21'sd0,       21'sd0,       1'b1, 19'sd0,       1'b0},
         '{FUNC_QUERY, 6'd0,  18'sd0,      -21'sd1048576, 21'sd0,       1'b1, 19'sd0,       1'b1},
         '{FUNC_QUERY, 6'd0,  18'sd0,       21'sd1048575, 21'sd0,       1'b1, 19'sd0,       1'b1},
         '{FUNC_QUERY, 6'd0,  18'sd0,       21'sd0,       21'sd1048575, 1'b1, 19'sd0,       1'b1},
         '{FUNC_QUERY, 6'd0,  18'sd0,       21'sd0,      -21'sd1048576, 1'b1, 19'sd0,       1'b1},
         '{FUNC_WRITE, 6'd0,  18'sd131071,  21'sd0,       21'sd0,       1'b0, 19'sd0,       1'b0},
         '{FUNC_WRITE, 6'd1, -18'sd131072,  21'sd0,       21'sd0,       1'b0, 19'sd0,       1'b0},
         '{FUNC_WRITE, 6'd5, -18'sd131072,  21'sd0,       21'sd0,       1'b0, 19'sd0,       1'b0},
         '{FUNC_WRITE, 6'd6,  18'sd4096,    21'sd0,       21'sd0,       1'b0, 19'sd0,       1'b0},
         // exactly on a grid point
         '{FUNC_QUERY, 6'd0,  18'sd0,       21'sd0,       21'sd0,       1'b1, 19'sd131071,  1'b0},
         // one cell below zero: extrapolation runs into positive saturation
         '{FUNC_QUERY, 6'd0,  18'sd0,      -21'sd51200,   21'sd0,       1'b1, 19'sd262143,  1'b0},
         '{FUNC_QUERY, 6'd0,  18'sd0,       21'sd0,      -21'sd51200,   1'b0, 19'sd0,       1'b0},
         '{FUNC_QUERY, 6'd0,  18'sd0,      -21'sd1,      -21'sd1,       1'b0, 19'sd0,       1'b0},
         '{FUNC_QUERY, 6'd0,  18'sd0,       21'sd25600,   21'sd25600,   1'b0, 19'sd0,       1'b0},
         // last row: upper neighbour clamped
         '{FUNC_QUERY, 6'd0,  18'sd0,       21'sd230000,  21'sd230000,  1'b0, 19'sd0,       1'b0},
         '{FUNC_QUERY, 6'd0,  18'sd0,       21'sd255999,  21'sd0,       1'b0, 19'sd0,       1'b0},
         // first count past the last row
         '{FUNC_QUERY, 6'd0,  18'sd0,       21'sd256001,  21'sd0,       1'b1, 19'sd0,       1'b1},
         '{FUNC_WRITE, 6'd0, -18'sd131072,  21'sd0,       21'sd0,       1'b0, 19'sd0,       1'b0},
         '{FUNC_WRITE, 6'd5,  18'sd131071,  21'sd0,       21'sd0,       1'b0, 19'sd0,       1'b0},
         // same extrapolation, signs swapped: negative saturation
         '{FUNC_QUERY, 6'd0,  18'sd0,      -21'sd51200,   21'sd0,       1'b1, -19'sd262144, 1'b0},
         '{FUNC_WRITE, 6'd63, -18'sd1,      21'sd0,       21'sd0,       1'b0, 19'sd0,       1'b0},
         '{FUNC_WRITE, 6'd24, 18'sd12345,   21'sd0,       21'sd0,       1'b0, 19'sd0,       1'b0},
         // top corner, both neighbours clamped
         '{FUNC_QUERY, 6'd0,  18'sd0,       21'sd255999,  21'sd255999,  1'b0, 19'sd0,       1'b0}
      };

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         rq.func   = directed_rows[i].func;
         rq.entry  = directed_rows[i].entry;
         rq.height = directed_rows[i].height;
         rq.x      = directed_rows[i].x;
         rq.y      = directed_rows[i].y;
         send_request(rq, directed_rows[i].typed, directed_rows[i].z, directed_rows[i].oog);
         maybe_idle(9);
      end

      // Random phases. Each one reprograms every register while the block is
      // idle; sender gaps are light, then heavy, then none at all.
      for (int ph = 0; ph < NUM_PHASES; ph++) begin
         drain_pipeline();
         ph_xr = $urandom_range(131072, 4194303);
         ph_yr = $urandom_range(131072, 4194303);
         case (ph)
            0:       begin ph_rows = 8;  ph_cols = 8;  end
            1:       begin ph_rows = 2;  ph_cols = 2;  ph_xr = 24'hFFFFFF; end
            2:       begin ph_rows = 1;  ph_cols = 1;  end
            3:       begin ph_rows = 0;  ph_cols = 5;  end   // nothing in grid
            4:       begin ph_rows = 15; ph_cols = 15; ph_xr = 24'd1; end  // clamp to max
            5:       begin ph_rows = 3;  ph_cols = 7;  ph_yr = 24'd1; end
            6:       begin ph_rows = 5;  ph_cols = 2;  ph_yr = 24'hFFFFFF; end
            default: begin ph_rows = 8;  ph_cols = 3;  end
         endcase
         // upper data bits are junk for the count registers
         csr_write(CSR_GRID_ROWS, {20'($urandom), ph_rows});
         csr_write(CSR_GRID_COLS, {20'($urandom), ph_cols});
         csr_write(CSR_X_RECIP, ph_xr);
         csr_write(CSR_Y_RECIP, ph_yr);
         if (ph == 6) csr_write(CSR_UNMAPPED, 24'($urandom));
         csr_valid <= 1'b0;
         @(posedge clock);

         idle_pct = (ph < 3) ? 9 : ((ph < 6) ? 70 : 0);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            rq.func   = ($urandom_range(0, 99) < 30) ? FUNC_WRITE : FUNC_QUERY;
            rq.entry  = ENTRY_W'($urandom);
            rq.height = pick_height();
            rq.x      = pick_pos(x_recip_cfg, rows_cfg);
            rq.y      = pick_pos(y_recip_cfg, cols_cfg);
            send_request(rq, 1'b0, '0, 1'b0);
            maybe_idle(idle_pct);
         end
      end

      drain_pipeline();
      if (pending_offsets.size() != 0)
         note_failure($sformatf("%0d results never arrived", pending_offsets.size()));

      if (fail_count == 0) begin
         $display("[bilinear_grid_height_offset] OK");
      end else begin
         $display("[bilinear_grid_height_offset] ERROR");
      end
      $finish;
   end

endmodule
